FILE: sv/hilp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hilp_pkg;

    localparam int KEY_W       = 31;
    localparam int CFG_W       = 10;
    localparam int SLOT_W      = 9;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 24;
    localparam int STEP_CNT_W  = $clog2(KEY_W);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD_KEY,
        ST_HOME_RD,
        ST_HOME_CHK,
        ST_MOD_OCC,
        ST_PROBE_RD,
        ST_PROBE_CHK,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

FILE: sv/hilp_modu.sv
`timescale 1ns / 1ps
`default_nettype none

module hilp_modu import hilp_pkg::*; #(
    parameter int IW  = 9,
    parameter int SZW = 10
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_start,
    input  wire  [KEY_W-1:0] i_num,
    input  wire  [SZW-1:0]   i_divisor,
    output logic             o_done,
    output logic [IW-1:0]    o_rem
);

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_CNT_W-1:0] r_cnt;
    logic [KEY_W-1:0]      r_num;
    logic [IW-1:0]         r_rem;

    logic [IW:0]           w_shift;
    logic [IW:0]           w_div;
    logic [IW:0]           w_diff;
    logic [IW-1:0]         n_rem;

    // one restoring step a cycle: bring in the next dividend bit, subtract if it fits
    always_comb begin
        w_shift = {r_rem, r_num[KEY_W-1]};
        w_div   = (IW+1)'(i_divisor);
        w_diff  = w_shift - w_div;
        if (w_shift >= w_div) begin
            n_rem = w_diff[IW-1:0];
        end else begin
            n_rem = w_shift[IW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_cnt <= STEP_CNT_W'(KEY_W - 1);
        end else if (r_busy) begin
            r_num <= {r_num[KEY_W-2:0], 1'b0};
            r_rem <= n_rem;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

FILE: sv/hilp_store.sv
`timescale 1ns / 1ps
`default_nettype none

module hilp_store import hilp_pkg::*; #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  wire              i_clk,
    input  wire              i_we,
    input  wire  [AW-1:0]    i_waddr,
    input  wire  [KEY_W-1:0] i_wdata,
    input  wire  [AW-1:0]    i_raddr,
    output logic [KEY_W-1:0] o_rdata
);

    logic [KEY_W-1:0] r_mem [DEPTH];
    logic [KEY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: sv/hash_insert_linear_probe_replace.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                          payload
// s_axis    in         i_s_axis_tvalid / o_s_axis_tready  key
// m_axis    out        o_m_axis_tvalid / i_m_axis_tready  added, home_slot, displaced, placed_slot
// cfg       in         i_cfg_valid / o_cfg_ready          table_size
//
// Each word goes through a bit-serial remainder unit.
// Empty home slot: one modulo. Collision: a modulo of the occupant, then a read per probed slot.
// After reset a clearing pass writes every slot, with no key taken.
// One word is held in the output register, so the next key is taken while it waits.

module hash_insert_linear_probe_replace import hilp_pkg::*; #(
    parameter int TABLE_SIZE = 512
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  wire [IN_TDATA_W-1:0]   i_s_axis_tdata,   // [30:0] key
    output logic                   o_m_axis_tvalid,
    input  wire                    i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,   // [0] added, [9:1] home_slot,
                                                     // [10] displaced, [19:11] placed_slot
    input  wire                    i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire  [CFG_W-1:0]       i_cfg_data
);

    localparam int IW  = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int SZW = $clog2(TABLE_SIZE + 1);

    t_state                 r_state, n_state;
    logic [SZW-1:0]         r_size, n_size;
    logic [IW-1:0]          r_clr, n_clr;
    logic [KEY_W-1:0]       r_key, n_key;
    logic [SZW-1:0]         r_sz, n_sz;
    logic [IW-1:0]          r_home, n_home;
    logic [KEY_W-1:0]       r_occ, n_occ;
    logic [IW-1:0]          r_idx, n_idx;
    logic [SZW-1:0]         r_pcnt, n_pcnt;
    logic                   r_disp, n_disp;
    logic                   r_added, n_added;
    logic [IW-1:0]          r_placed, n_placed;
    logic                   r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;

    logic                   w_accept;
    logic [31:0]            w_cfg_val;
    logic [SZW-1:0]         w_idx_inc;
    logic [IW-1:0]          w_idx_next;
    logic                   w_out_free;
    logic [31:0]            w_home_ext;
    logic [31:0]            w_placed_ext;

    logic                   w_mod_start;
    logic [KEY_W-1:0]       w_mod_num;
    logic                   w_mod_done;
    logic [IW-1:0]          w_mod_rem;

    logic                   w_we;
    logic [IW-1:0]          w_waddr;
    logic [KEY_W-1:0]       w_wdata;
    logic [IW-1:0]          w_raddr;
    logic [KEY_W-1:0]       w_rdata;

    hilp_modu #(
        .IW  (IW),
        .SZW (SZW)
    ) u_modu (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mod_start),
        .i_num     (w_mod_num),
        .i_divisor (r_sz),
        .o_done    (w_mod_done),
        .o_rem     (w_mod_rem)
    );

    hilp_store #(
        .DEPTH (TABLE_SIZE),
        .AW    (IW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    assign w_accept     = i_s_axis_tvalid && (r_state == ST_IDLE);
    assign w_out_free   = !r_out_valid || i_m_axis_tready;
    assign w_idx_inc    = SZW'(r_idx) + SZW'(1);
    assign w_idx_next   = (w_idx_inc == r_sz) ? '0 : w_idx_inc[IW-1:0];
    assign w_home_ext   = 32'(r_home);
    assign w_placed_ext = 32'(r_placed);

    // clamp the written size to 1..TABLE_SIZE
    always_comb begin
        w_cfg_val = 32'(i_cfg_data);
        if (w_cfg_val == 32'd0) begin
            w_cfg_val = 32'd1;
        end else if (w_cfg_val > 32'(TABLE_SIZE)) begin
            w_cfg_val = 32'(TABLE_SIZE);
        end
        n_size = r_size;
        if (i_cfg_valid) begin
            n_size = w_cfg_val[SZW-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == IW'(TABLE_SIZE - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = ST_MOD_KEY;
                end
            end
            ST_MOD_KEY: begin
                if (w_mod_done) begin
                    n_state = ST_HOME_RD;
                end
            end
            ST_HOME_RD: begin
                n_state = ST_HOME_CHK;
            end
            ST_HOME_CHK: begin
                if (w_rdata == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_MOD_OCC;
                end
            end
            ST_MOD_OCC: begin
                if (w_mod_done) begin
                    if (r_pcnt < r_sz) begin
                        n_state = ST_PROBE_RD;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_PROBE_RD: begin
                n_state = ST_PROBE_CHK;
            end
            ST_PROBE_CHK: begin
                if (w_rdata == '0) begin
                    n_state = ST_DONE;
                end else if ((r_pcnt + SZW'(1)) < r_sz) begin
                    n_state = ST_PROBE_RD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_clr       = r_clr;
        n_key       = r_key;
        n_sz        = r_sz;
        n_home      = r_home;
        n_occ       = r_occ;
        n_idx       = r_idx;
        n_pcnt      = r_pcnt;
        n_disp      = r_disp;
        n_added     = r_added;
        n_placed    = r_placed;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;
        w_mod_start = 1'b0;
        w_mod_num   = r_key;
        w_we        = 1'b0;
        w_waddr     = r_home;
        w_wdata     = r_key;
        w_raddr     = r_home;
        case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
                n_clr   = r_clr + 1'b1;
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_key       = i_s_axis_tdata[KEY_W-1:0];
                    n_sz        = r_size;
                    n_disp      = 1'b0;
                    n_added     = 1'b0;
                    n_placed    = '0;
                    w_mod_start = 1'b1;
                    w_mod_num   = i_s_axis_tdata[KEY_W-1:0];
                end
            end
            ST_MOD_KEY: begin
                if (w_mod_done) begin
                    n_home = w_mod_rem;
                end
            end
            ST_HOME_RD: begin
                w_raddr = r_home;
            end
            ST_HOME_CHK: begin
                if (w_rdata == '0) begin
                    w_we     = 1'b1;
                    n_added  = 1'b1;
                    n_placed = r_home;
                end else begin
                    n_occ       = w_rdata;
                    w_mod_start = 1'b1;
                    w_mod_num   = w_rdata;
                    n_pcnt      = SZW'(1);
                    n_idx       = r_home;
                end
            end
            ST_MOD_OCC: begin
                // occupant from another home: evict it, key takes the home slot
                if (w_mod_done && w_mod_rem != r_home) begin
                    n_disp = 1'b1;
                    w_we   = 1'b1;
                end
            end
            ST_PROBE_RD: begin
                w_raddr = w_idx_next;
                n_idx   = w_idx_next;
            end
            ST_PROBE_CHK: begin
                if (w_rdata == '0) begin
                    w_we     = 1'b1;
                    w_waddr  = r_idx;
                    w_wdata  = r_disp ? r_occ : r_key;
                    n_added  = 1'b1;
                    n_placed = r_idx;
                end else begin
                    n_pcnt = r_pcnt + SZW'(1);
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {4'b0000, w_placed_ext[SLOT_W-1:0], r_disp,
                                   w_home_ext[SLOT_W-1:0], r_added};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_size      <= SZW'(TABLE_SIZE);
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_size      <= n_size;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_sz       <= n_sz;
        r_home     <= n_home;
        r_occ      <= n_occ;
        r_idx      <= n_idx;
        r_pcnt     <= n_pcnt;
        r_disp     <= n_disp;
        r_added    <= n_added;
        r_placed   <= n_placed;
        r_out_data <= n_out_data;
    end

endmodule

`default_nettype wire

FILE: tb/tb_hash_insert_linear_probe_replace.sv
`timescale 1ns / 1ps

module tb_hash_insert_linear_probe_replace;
    import hilp_pkg::*;

    localparam int MAX_SLOTS  = 512;
    localparam int IDLE_LIMIT = 10000;
    localparam int N_DIR      = 25;
    localparam int N_PHASES   = 13;

    typedef enum logic {
        ROW_KEY,
        ROW_SIZE
    } t_row_kind;

    typedef struct packed {
        logic              added;
        logic [SLOT_W-1:0] home_slot;
        logic              displaced;
        logic [SLOT_W-1:0] placed_slot;
    } t_ins_res;

    typedef struct packed {
        t_row_kind        kind;
        logic             typed;
        logic [KEY_W-1:0] value;
        t_ins_res         want;
    } t_dir_row;

    localparam t_dir_row DIR_ROWS [N_DIR] = '{
        '{ROW_KEY,  1'b1, 31'h7FFF_FFFF, '{1'b1, 9'd511, 1'b0, 9'd511}},
        '{ROW_KEY,  1'b1, 31'd0,         '{1'b1, 9'd0,   1'b0, 9'd0}},
        '{ROW_KEY,  1'b1, 31'd511,       '{1'b1, 9'd511, 1'b0, 9'd0}},
        '{ROW_KEY,  1'b1, 31'd512,       '{1'b1, 9'd0,   1'b1, 9'd1}},
        '{ROW_KEY,  1'b1, 31'd1024,      '{1'b1, 9'd0,   1'b0, 9'd2}},
        '{ROW_SIZE, 1'b0, 31'd0,         '0},
        '{ROW_KEY,  1'b1, 31'd5,         '{1'b0, 9'd0,   1'b0, 9'd0}},
        '{ROW_KEY,  1'b1, 31'd0,         '{1'b0, 9'd0,   1'b0, 9'd0}},
        '{ROW_SIZE, 1'b0, 31'd2,         '0},
        '{ROW_KEY,  1'b1, 31'd3,         '{1'b0, 9'd1,   1'b0, 9'd0}},
        '{ROW_KEY,  1'b1, 31'd4,         '{1'b0, 9'd0,   1'b0, 9'd0}},
        '{ROW_SIZE, 1'b0, 31'd3,         '0},
        '{ROW_KEY,  1'b1, 31'd6,         '{1'b0, 9'd0,   1'b1, 9'd0}},
        '{ROW_SIZE, 1'b0, 31'd1023,      '0},
        '{ROW_KEY,  1'b1, 31'h7FFF_FE00, '{1'b1, 9'd0,   1'b1, 9'd3}},
        '{ROW_KEY,  1'b1, 31'd3,         '{1'b1, 9'd3,   1'b1, 9'd4}},
        '{ROW_KEY,  1'b1, 31'h5555_5555, '{1'b1, 9'd341, 1'b0, 9'd341}},
        '{ROW_KEY,  1'b1, 31'h2AAA_AAAA, '{1'b1, 9'd170, 1'b0, 9'd170}},
        '{ROW_KEY,  1'b1, 31'h2AAA_AAAA, '{1'b1, 9'd170, 1'b0, 9'd171}},
        '{ROW_SIZE, 1'b0, 31'd300,       '0},
        '{ROW_KEY,  1'b0, 31'd299,       '0},
        '{ROW_KEY,  1'b0, 31'd300,       '0},
        '{ROW_KEY,  1'b0, 31'd600,       '0},
        '{ROW_KEY,  1'b0, 31'h7FFF_FFFF, '0},
        '{ROW_KEY,  1'b0, 31'd899,       '0}
    };

    localparam logic [CFG_W-1:0] PHASE_SIZES [N_PHASES] = '{
        10'd1, 10'd2, 10'd5, 10'd16, 10'd37, 10'd0, 10'd100,
        10'd511, 10'd512, 10'd1023, 10'd64, 10'd200, 10'd8
    };

    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata  = '0;
    logic                   i_m_axis_tready = 1'b0;
    logic                   i_cfg_valid     = 1'b0;
    logic [CFG_W-1:0]       i_cfg_data      = '0;
    logic                   o_s_axis_tready;
    logic                   o_m_axis_tvalid;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_cfg_ready;

    logic [KEY_W-1:0] slot_mem [MAX_SLOTS];
    int unsigned      tbl_size;
    t_ins_res         pending_results [$];
    t_ins_res         got;
    t_ins_res         want;
    int               errors     = 0;
    int               idle_count = 0;
    logic             calm       = 1'b0;

    always #6 i_clk = ~i_clk;

    hash_insert_linear_probe_replace #(
        .TABLE_SIZE(MAX_SLOTS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    function automatic t_ins_res insert_key(input logic [KEY_W-1:0] key);
        int unsigned home;
        int unsigned occ;
        int unsigned idx;
        int unsigned free_idx;
        t_ins_res    res;
        res      = '0;
        home     = key % tbl_size;
        occ      = 32'(slot_mem[home]);
        free_idx = tbl_size;
        if (occ == 0) begin
            slot_mem[home] = key;
            res.added       = 1'b1;
            res.placed_slot = SLOT_W'(home);
        end else begin
            // evict a misplaced occupant, then walk upward for a free slot
            if (occ % tbl_size != home) begin
                res.displaced  = 1'b1;
                slot_mem[home] = key;
            end
            idx = home;
            for (int n = 1; n < tbl_size; n++) begin
                idx = (idx + 1 == tbl_size) ? 0 : idx + 1;
                if (slot_mem[idx] == 0) begin
                    free_idx = idx;
                    break;
                end
            end
            if (free_idx < tbl_size) begin
                slot_mem[free_idx] = res.displaced ? occ[KEY_W-1:0] : key;
                res.added       = 1'b1;
                res.placed_slot = SLOT_W'(free_idx);
            end
        end
        res.home_slot = SLOT_W'(home);
        return res;
    endfunction

    task automatic wait_idle();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_size(input logic [CFG_W-1:0] value);
        i_s_axis_tvalid <= 1'b0;
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (value == 0)
            tbl_size = 1;
        else if (value > MAX_SLOTS)
            tbl_size = MAX_SLOTS;
        else
            tbl_size = 32'(value);
    endtask

    task automatic send_key(input logic [KEY_W-1:0] key, input logic typed,
                            input t_ins_res typed_res);
        t_ins_res res;
        while (!calm && $urandom_range(0, 99) < 8) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {1'b0, key};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        res = insert_key(key);
        pending_results.push_back(typed ? typed_res : res);
    endtask

    // sink side: random back-pressure, result check and watchdog
    always @(posedge i_clk) begin
        i_m_axis_tready <= calm || ($urandom_range(0, 99) >= 8);
        if (o_m_axis_tvalid && i_m_axis_tready) begin
            got.added       = o_m_axis_tdata[0];
            got.home_slot   = o_m_axis_tdata[9:1];
            got.displaced   = o_m_axis_tdata[10];
            got.placed_slot = o_m_axis_tdata[19:11];
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected word added=%0d home=%0d displaced=%0d placed=%0d",
                         $time, got.added, got.home_slot, got.displaced, got.placed_slot);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t: expected added=%0d home=%0d displaced=%0d placed=%0d",
                             $time, want.added, want.home_slot, want.displaced,
                             want.placed_slot);
                    $display("%0t: actual   added=%0d home=%0d displaced=%0d placed=%0d",
                             $time, got.added, got.home_slot, got.displaced,
                             got.placed_slot);
                end
            end
        end
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_count <= 0;
        end else begin
            idle_count <= idle_count + 1;
        end
        if (idle_count >= IDLE_LIMIT) begin
            $display("FAIL hash_insert_linear_probe_replace");
            $finish;
        end
    end

    initial begin
        int               count;
        int               pick;
        logic [KEY_W-1:0] key;
        foreach (slot_mem[i]) slot_mem[i] = '0;
        tbl_size = MAX_SLOTS;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_DIR; r++) begin
            if (DIR_ROWS[r].kind == ROW_SIZE) begin
                write_size(DIR_ROWS[r].value[CFG_W-1:0]);
            end else begin
                send_key(DIR_ROWS[r].value, DIR_ROWS[r].typed, DIR_ROWS[r].want);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_size(PHASE_SIZES[ph]);
            calm  <= (ph == 3 || ph == 4);
            count = (tbl_size >= 256) ? 40 : 80;
            for (int i = 0; i < count; i++) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    key = '0;
                end else if (pick < 5) begin
                    key = KEY_W'($urandom);
                end else begin
                    // cluster homes low in the table to force probing and eviction
                    key = KEY_W'($urandom_range(0, 4194303) * tbl_size
                          + $urandom_range(0, (tbl_size > 8) ? tbl_size / 4 : tbl_size - 1));
                end
                send_key(key, 1'b0, '0);
            end
        end
        i_s_axis_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS hash_insert_linear_probe_replace");
        end else begin
            $display("FAIL hash_insert_linear_probe_replace");
        end
        $finish;
    end

endmodule
